@@ design/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Beat formats, register map, count and case codes, and the records that
// travel beside the data through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

	// Coefficient and root format
	localparam int DATA_W = 32;

	// Register map
	localparam int THR_W     = 16;
	localparam int APB_W     = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_THR = 1'b0;
	localparam logic [THR_W-1:0]     THR_RESET    = 16'd1;

	// Internal widths
	localparam int DEN_W  = DATA_W + 1;      // 2*|a| or |b|
	localparam int DIV_W  = DATA_W + 2;      // divider denominator 2*den
	localparam int NUM_W  = DATA_W + 2;      // magnitude of -b +/- s
	localparam int SUM_W  = DATA_W + 3;      // signed -b +/- s
	localparam int DISC_W = 2 * DATA_W + 2;  // discriminant, even width
	localparam int SQRT_W = DATA_W + 2;      // rounded square root

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2,
		CNT_INF  = 2'd3
	} cnt_t;

	typedef enum logic [1:0] {
		KIND_FIX  = 2'd0,
		KIND_LIN  = 2'd1,
		KIND_QUAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] coef_a;
		logic signed [DATA_W-1:0] coef_b;
		logic signed [DATA_W-1:0] coef_c;
	} coef_beat_t;

	typedef struct packed {
		logic [1:0]               root_count;
		logic signed [DATA_W-1:0] root_one;
		logic signed [DATA_W-1:0] root_two;
		logic                     overflow;
	} root_beat_t;

	// Sign-magnitude view of the coefficients
	typedef struct packed {
		logic              a_neg;
		logic [DATA_W-1:0] a_mag;
		logic              b_neg;
		logic [DATA_W-1:0] b_mag;
		logic [DATA_W-1:0] b_raw;
		logic              c_neg;
		logic [DATA_W-1:0] c_mag;
	} coef_t;

	// Carried beside the square root
	typedef struct packed {
		kind_t kind;
		cnt_t  cnt;
		logic  have;
		coef_t co;
	} sq_sb_t;

	// Per-root flags carried beside a quotient
	typedef struct packed {
		logic act;  // root present
		logic sgn;  // sign of numerator xor sign of divisor
		logic dz;   // divisor is zero
		logic nz;   // numerator is zero
	} rt_t;

	typedef struct packed {
		cnt_t cnt;
		rt_t  r1;
	} dv_sb_t;

endpackage

`default_nettype wire

@@ design/qrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root, rounded to nearest
// One result bit per stage by the digit-by-digit remainder method, then a
// rounding stage. A sideband word travels with each value.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt #(
	parameter int IN_W = 66,
	parameter int SB_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_v,
	input  wire logic [IN_W-1:0]   in_x,
	input  wire logic [SB_W-1:0]   in_sb,
	output logic                   out_v,
	output logic [IN_W/2:0]        out_root,
	output logic [SB_W-1:0]        out_sb
);

	localparam int R = IN_W / 2;

	logic            v_s  [1:R];
	logic [IN_W-1:0] x_s  [1:R];
	logic [R-1:0]    q_s  [1:R];
	logic [R+1:0]    r_s  [1:R];
	logic [SB_W-1:0] sb_s [1:R];

	logic            v_sr;
	logic [R:0]      root_sr;
	logic [SB_W-1:0] sb_sr;

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic            pv;
		logic [IN_W-1:0] px;
		logic [R-1:0]    pq;
		logic [R+1:0]    pr;
		logic [SB_W-1:0] psb;
		logic [R+3:0]    trial;
		logic [R+3:0]    tval;
		logic [R+3:0]    diff;
		logic            fit;

		if (k == 0) begin : g_src_in
			assign pv  = in_v;
			assign px  = in_x;
			assign pq  = '0;
			assign pr  = '0;
			assign psb = in_sb;
		end else begin : g_src_prev
			assign pv  = v_s[k];
			assign px  = x_s[k];
			assign pq  = q_s[k];
			assign pr  = r_s[k];
			assign psb = sb_s[k];
		end

		// try the next root bit against the shifted remainder
		assign trial = {pr, px[IN_W-1-2*k -: 2]};
		assign tval  = {2'b00, pq, 2'b01};
		assign diff  = trial - tval;
		assign fit   = (trial >= tval);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[k+1]  <= px;
				q_s[k+1]  <= {pq[R-2:0], fit};
				r_s[k+1]  <= fit ? diff[R+1:0] : trial[R+1:0];
				sb_s[k+1] <= psb;
			end
		end
	end

	// round up when the remainder exceeds the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else if (adv) begin
			v_sr <= v_s[R];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_sr <= {1'b0, q_s[R]} + {{R{1'b0}}, (r_s[R] > {2'b00, q_s[R]})};
			sb_sr   <= sb_s[R];
		end
	end

	assign out_v    = v_sr;
	assign out_root = root_sr;
	assign out_sb   = sb_sr;

endmodule

`default_nettype wire

@@ design/qrs_div.sv @@
// ----------------------------------------------------------------------------
// qrs_div: pipelined restoring divider
// One quotient bit per stage, floor of numerator over denominator. A
// sideband word travels with each pair.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
	parameter int NN   = 52,
	parameter int DD   = 34,
	parameter int SB_W = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            in_v,
	input  wire logic [NN-1:0]   in_n,
	input  wire logic [DD-1:0]   in_d,
	input  wire logic [SB_W-1:0] in_sb,
	output logic                 out_v,
	output logic [NN-1:0]        out_q,
	output logic [SB_W-1:0]      out_sb
);

	logic            v_s  [1:NN];
	logic [NN-1:0]   n_s  [1:NN];
	logic [DD-1:0]   d_s  [1:NN];
	logic [NN-1:0]   q_s  [1:NN];
	logic [DD-1:0]   r_s  [1:NN];
	logic [SB_W-1:0] sb_s [1:NN];

	for (genvar k = 0; k < NN; k++) begin : g_stage
		logic            pv;
		logic [NN-1:0]   pn;
		logic [DD-1:0]   pd;
		logic [NN-1:0]   pq;
		logic [DD-1:0]   pr;
		logic [SB_W-1:0] psb;
		logic [DD:0]     trial;
		logic [DD:0]     diff;
		logic            fit;

		if (k == 0) begin : g_src_in
			assign pv  = in_v;
			assign pn  = in_n;
			assign pd  = in_d;
			assign pq  = '0;
			assign pr  = '0;
			assign psb = in_sb;
		end else begin : g_src_prev
			assign pv  = v_s[k];
			assign pn  = n_s[k];
			assign pd  = d_s[k];
			assign pq  = q_s[k];
			assign pr  = r_s[k];
			assign psb = sb_s[k];
		end

		// shift in the next numerator bit and subtract when it fits
		assign trial = {pr, pn[NN-1-k]};
		assign diff  = trial - {1'b0, pd};
		assign fit   = (trial >= {1'b0, pd});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[k+1]  <= pn;
				d_s[k+1]  <= pd;
				q_s[k+1]  <= {pq[NN-2:0], fit};
				r_s[k+1]  <= fit ? diff[DD-1:0] : trial[DD-1:0];
				sb_s[k+1] <= psb;
			end
		end
	end

	assign out_v  = v_s[NN];
	assign out_q  = q_s[NN];
	assign out_sb = sb_s[NN];

endmodule

`default_nettype wire

@@ design/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0 in fixed point
// Pipelined solver: coefficient decode, products, discriminant, square root,
// numerators and two quotient dividers feeding one output register.
// ----------------------------------------------------------------------------
// Usage:
//   coef channel (coef_valid / coef_stall / coef) carries a, b, c as signed
//   Q16.16. root channel (root_valid / root_stall / root) returns the count
//   code, two roots and an overflow flag, one beat per coefficient beat, in
//   order. The APB port holds zero_threshold at byte address 0; write it only
//   while the pipeline is empty.
//   Throughput: one beat per cycle while root_stall does not hold a waiting
//   beat. The pipeline depth is set by the square root, one stage per root
//   bit, and the dividers, one stage per quotient bit.
//   Every stage moves on the same enable. When root_stall holds a waiting
//   beat, the whole pipeline freezes and coef_stall is raised in the same
//   cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and sets zero_threshold to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        coef_valid,
	output logic                             coef_stall,
	input  wire qrs_pkg::coef_beat_t         coef,
	output logic                             root_valid,
	input  wire logic                        root_stall,
	output qrs_pkg::root_beat_t              root,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [qrs_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [qrs_pkg::APB_W-1:0]   pwdata,
	output logic [qrs_pkg::APB_W-1:0]        prdata,
	output logic                             pready
);

	import qrs_pkg::*;

	localparam int W     = DATA_W;
	localparam int NN    = NUM_W + FRAC_BITS + 2;
	localparam int SQ_SB = $bits(sq_sb_t);
	localparam int D1_SB = $bits(dv_sb_t);
	localparam int D2_SB = $bits(rt_t);

	logic adv;

	// ---------------- configuration ----------------
	logic [THR_W-1:0]     thr_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && (reg_idx == REG_ZERO_THR)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_ZERO_THR) ? {{(APB_W-THR_W){1'b0}}, thr_q} : '0;

	// ---------------- stage 1: decode ----------------
	logic          v_s1;
	coef_t         co_s1;
	logic          za_s1, zb_s1, zc_s1;
	logic [W-1:0]  am, bm, cm;
	logic [W-1:0]  thr_x;

	assign am    = coef.coef_a[W-1] ? (~coef.coef_a + 1'b1) : coef.coef_a;
	assign bm    = coef.coef_b[W-1] ? (~coef.coef_b + 1'b1) : coef.coef_b;
	assign cm    = coef.coef_c[W-1] ? (~coef.coef_c + 1'b1) : coef.coef_c;
	assign thr_x = {{(W-THR_W){1'b0}}, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			co_s1.a_neg <= coef.coef_a[W-1];
			co_s1.a_mag <= am;
			co_s1.b_neg <= coef.coef_b[W-1];
			co_s1.b_mag <= bm;
			co_s1.b_raw <= coef.coef_b;
			co_s1.c_neg <= coef.coef_c[W-1];
			co_s1.c_mag <= cm;
			za_s1       <= (am < thr_x);
			zb_s1       <= (bm < thr_x);
			zc_s1       <= (cm < thr_x);
		end
	end

	// ---------------- stage 2: classify and multiply ----------------
	logic           v_s2;
	coef_t          co_s2;
	kind_t          kind_s2;
	cnt_t           cnt_s2;
	logic [2*W-1:0] bb_s2, ac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			co_s2   <= co_s1;
			kind_s2 <= !za_s1 ? KIND_QUAD : (!zb_s1 ? KIND_LIN : KIND_FIX);
			cnt_s2  <= zc_s1 ? CNT_INF : CNT_NONE;
			bb_s2   <= co_s1.b_mag * co_s1.b_mag;
			ac_s2   <= co_s1.a_mag * co_s1.c_mag;
		end
	end

	// ---------------- stage 3: discriminant ----------------
	logic              v_s3;
	logic [DISC_W-1:0] disc_s3;
	sq_sb_t            sb_s3;
	logic [DISC_W-1:0] bbx, ac4, disc_c;
	logic              have_c;

	assign bbx = {2'b00, bb_s2};
	assign ac4 = {ac_s2, 2'b00};

	always_comb begin
		have_c = 1'b1;
		if (co_s2.a_neg != co_s2.c_neg) begin
			disc_c = bbx + ac4;
		end else if (bbx < ac4) begin
			have_c = 1'b0;
			disc_c = '0;
		end else begin
			disc_c = bbx - ac4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s3      <= disc_c;
			sb_s3.kind   <= kind_s2;
			sb_s3.cnt    <= cnt_s2;
			sb_s3.have   <= have_c;
			sb_s3.co     <= co_s2;
		end
	end

	// ---------------- square root ----------------
	logic              sq_v;
	logic [SQRT_W-1:0] sq_root;
	logic [SQ_SB-1:0]  sq_sbv;

	qrs_sqrt #(
		.IN_W (DISC_W),
		.SB_W (SQ_SB)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s3),
		.in_x     (disc_s3),
		.in_sb    (SQ_SB'(sb_s3)),
		.out_v    (sq_v),
		.out_root (sq_root),
		.out_sb   (sq_sbv)
	);

	// ---------------- stage 4: -b +/- s ----------------
	logic                    v_s4;
	sq_sb_t                  sb_s4;
	logic                    sz_s4;
	logic signed [SUM_W-1:0] sp_s4, spn_s4, sn_s4, snn_s4;
	sq_sb_t                  sq_sb;
	logic signed [SUM_W-1:0] b_ext, s_ext;

	assign sq_sb = sq_sb_t'(sq_sbv);
	assign b_ext = {{(SUM_W-W){sq_sb.co.b_raw[W-1]}}, sq_sb.co.b_raw};
	assign s_ext = {1'b0, sq_root};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s4  <= sq_sb;
			sz_s4  <= (sq_root == '0);
			sp_s4  <= s_ext - b_ext;
			spn_s4 <= b_ext - s_ext;
			sn_s4  <= '0 - b_ext - s_ext;
			snn_s4 <= b_ext + s_ext;
		end
	end

	// ---------------- stage 5: divider operands ----------------
	logic             v_s5;
	logic [NN-1:0]    n1_s5, n2_s5;
	logic [DIV_W-1:0] dd_s5;
	dv_sb_t           dsb1_s5;
	rt_t              rt2_s5;

	cnt_t             cnt_c;
	rt_t              r1_c, r2_c;
	logic [NUM_W-1:0] num1_c, num2_c;
	logic [DEN_W-1:0] den_c;
	coef_t            co4;

	assign co4 = sb_s4.co;

	// pick numerator and divisor for the case at hand
	always_comb begin
		cnt_c  = sb_s4.cnt;
		r1_c   = '0;
		r2_c   = '0;
		num1_c = '0;
		num2_c = '0;
		den_c  = {co4.a_mag, 1'b0};
		case (sb_s4.kind)
			KIND_LIN: begin
				den_c    = {1'b0, co4.b_mag};
				num1_c   = {2'b00, co4.c_mag};
				r1_c.act = 1'b1;
				r1_c.sgn = (!co4.c_neg && (co4.c_mag != '0)) ^ co4.b_neg;
				cnt_c    = CNT_ONE;
			end
			KIND_QUAD: begin
				if (!sb_s4.have) begin
					cnt_c = CNT_NONE;
				end else if (sz_s4) begin
					num1_c   = {2'b00, co4.b_mag};
					r1_c.act = 1'b1;
					r1_c.sgn = (!co4.b_neg && (co4.b_mag != '0)) ^ co4.a_neg;
					cnt_c    = CNT_ONE;
				end else begin
					num1_c   = sp_s4[SUM_W-1] ? spn_s4[NUM_W-1:0] : sp_s4[NUM_W-1:0];
					num2_c   = sn_s4[SUM_W-1] ? snn_s4[NUM_W-1:0] : sn_s4[NUM_W-1:0];
					r1_c.act = 1'b1;
					r2_c.act = 1'b1;
					r1_c.sgn = sp_s4[SUM_W-1] ^ co4.a_neg;
					r2_c.sgn = sn_s4[SUM_W-1] ^ co4.a_neg;
					cnt_c    = CNT_TWO;
				end
			end
			default: begin
				cnt_c = sb_s4.cnt;
			end
		endcase
		r1_c.dz = (den_c == '0);
		r2_c.dz = (den_c == '0);
		r1_c.nz = (num1_c == '0);
		r2_c.nz = (num2_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	// round to nearest: (2*n*2^F + d) / (2*d)
	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s5       <= {1'b0, num1_c, {(FRAC_BITS+1){1'b0}}} + NN'(den_c);
			n2_s5       <= {1'b0, num2_c, {(FRAC_BITS+1){1'b0}}} + NN'(den_c);
			dd_s5       <= {den_c, 1'b0};
			dsb1_s5.cnt <= cnt_c;
			dsb1_s5.r1  <= r1_c;
			rt2_s5      <= r2_c;
		end
	end

	// ---------------- dividers ----------------
	logic             dv1_v, dv2_v;
	logic [NN-1:0]    q1, q2;
	logic [D1_SB-1:0] dv1_sbv;
	logic [D2_SB-1:0] dv2_sbv;
	dv_sb_t           dv1_sb;
	rt_t              dv2_rt;

	qrs_div #(
		.NN   (NN),
		.DD   (DIV_W),
		.SB_W (D1_SB)
	) u_div_one (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (v_s5),
		.in_n   (n1_s5),
		.in_d   (dd_s5),
		.in_sb  (D1_SB'(dsb1_s5)),
		.out_v  (dv1_v),
		.out_q  (q1),
		.out_sb (dv1_sbv)
	);

	qrs_div #(
		.NN   (NN),
		.DD   (DIV_W),
		.SB_W (D2_SB)
	) u_div_two (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (v_s5),
		.in_n   (n2_s5),
		.in_d   (dd_s5),
		.in_sb  (D2_SB'(rt2_s5)),
		.out_v  (dv2_v),
		.out_q  (q2),
		.out_sb (dv2_sbv)
	);

	assign dv1_sb = dv_sb_t'(dv1_sbv);
	assign dv2_rt = rt_t'(dv2_sbv);

	// ---------------- output register ----------------
	function automatic logic [W:0] emit_root(rt_t rt, logic [NN-1:0] q);
		logic          neg;
		logic          ovf;
		logic [NN-1:0] lim;
		logic [W-1:0]  mag;
		logic [W-1:0]  val;
		neg = 1'b0;
		ovf = 1'b0;
		lim = '0;
		mag = '0;
		val = '0;
		if (!rt.act) begin
			val = '0;
		end else if (rt.dz) begin
			ovf = 1'b1;
			if (rt.nz) begin
				val = '0;
			end else begin
				val = rt.sgn ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end
		end else begin
			neg = rt.sgn && (q != '0);
			lim = neg ? {{(NN-W){1'b0}}, 1'b1, {(W-1){1'b0}}}
			          : {{(NN-W){1'b0}}, 1'b0, {(W-1){1'b1}}};
			if (q > lim) begin
				mag = lim[W-1:0];
				ovf = 1'b1;
			end else begin
				mag = q[W-1:0];
			end
			val = neg ? (~mag + 1'b1) : mag;
		end
		return {ovf, val};
	endfunction

	logic       rv_s6;
	root_beat_t rd_s6;
	logic [W:0] e1, e2;

	assign e1 = emit_root(dv1_sb.r1, q1);
	assign e2 = emit_root(dv2_rt, q2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s6 <= 1'b0;
		end else if (adv) begin
			rv_s6 <= dv1_v && dv2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s6.root_count <= dv1_sb.cnt;
			rd_s6.root_one   <= e1[W-1:0];
			rd_s6.root_two   <= e2[W-1:0];
			rd_s6.overflow   <= e1[W] | e2[W];
		end
	end

	// advance everything unless a finished beat is held
	assign adv        = !rv_s6 || !root_stall;
	assign coef_stall = !adv;
	assign root_valid = rv_s6;
	assign root       = rd_s6;

`ifndef SYNTHESIS
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv1_v == dv2_v)
		else $error("dividers out of step");

	a_empty_roots: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && (root.root_count == CNT_NONE || root.root_count == CNT_INF)
		|-> root.root_one == '0 && root.root_two == '0 && !root.overflow)
		else $error("root reported without a root count");

	a_one_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.root_count == CNT_ONE |-> root.root_two == '0)
		else $error("second root set on single root");

	a_thr_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && reg_idx == REG_ZERO_THR |=> thr_q == $past(pwdata[THR_W-1:0]))
		else $error("threshold write lost");
`endif

endmodule

`default_nettype wire
